// ===== rtl/lpht_pkg.sv =====
// Shared types and constants of the linear-probe hash table.
// Used by lpht_ctrl, lpht_dp, linear_probe_hash_table and the testbench; depends on nothing.
package lpht_pkg;

  localparam int CAPACITY = 256;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = IDX_W + 1;
  localparam int DATA_W   = 32;

  localparam logic [2:0] MODE_GET     = 3'd0;
  localparam logic [2:0] MODE_SET     = 3'd1;
  localparam logic [2:0] MODE_DELETE  = 3'd2;
  localparam logic [2:0] MODE_CLEAR   = 3'd3;
  localparam logic [2:0] MODE_ITERATE = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_END       = 2'd3;

  localparam logic [1:0] MARK_EMPTY   = 2'd0;
  localparam logic [1:0] MARK_DELETED = 2'd1;
  localparam logic [1:0] MARK_FULL    = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       accept;     // latch the request word and seed the probe
    logic       rd_en;      // read the slot memories at the current position
    logic       step;       // advance the position by one slot
    logic       wipe;       // mark the current slot empty
    logic       note_free;  // remember the current slot as the first free one
    logic       set_match;  // the current slot holds the requested key
    logic       finish;     // apply the update and load the result word
    logic [1:0] fin_status;
  } lpht_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [2:0] mode;
    logic       count_zero;
    logic       start_beyond;  // incoming start slot lies at or past the end
    logic       empty;         // mark of the slot read last
    logic       deleted;
    logic       full;
    logic       key_match;     // stored hash and key equal the request
    logic       probe_last;    // this is the last slot a probe may visit
    logic       pos_last;      // current position is the highest slot
    logic       has_free;
    logic       out_free;      // the result register can take a word
  } lpht_stat_t;

endpackage

// ===== rtl/lpht_dp.sv =====
// Datapath of the linear-probe hash table: slot marks, slot memories,
// probe position, entry count and the result register. Depends on lpht_pkg.
module lpht_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lpht_pkg::lpht_cmd_t        cmd,
  output lpht_pkg::lpht_stat_t       stat,
  input  logic [2:0]                 in_mode,
  input  logic [31:0]                in_key,
  input  logic [31:0]                in_key_hash,
  input  logic [31:0]                in_value,
  input  logic [8:0]                 in_start_slot,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 out_status,
  output logic                       out_is_new,
  output logic [7:0]                 out_slot,
  output logic [8:0]                 out_next_slot,
  output logic [31:0]                out_key,
  output logic [31:0]                out_hash,
  output logic [31:0]                out_value,
  output logic [8:0]                 out_entry_count
);
  import lpht_pkg::*;

  logic [DATA_W-1:0] hash_mem [CAPACITY];
  logic [DATA_W-1:0] key_mem  [CAPACITY];
  logic [DATA_W-1:0] val_mem  [CAPACITY];
  logic [1:0]        mark_mem [CAPACITY];
  logic [DATA_W-1:0] rd_hash_r, rd_key_r, rd_val_r;
  logic [1:0]        rd_mark_r;

  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                out_valid_r;

  logic [2:0]        mode_r;
  logic [DATA_W-1:0] key_r, hash_r, val_r;
  logic [CNT_W-1:0]  start_r;
  logic [IDX_W-1:0]  pos_r, n_r, free_r;
  logic              has_free_r, match_r;

  logic             ok, set_ok, del_ok, clr;
  logic [IDX_W-1:0] tgt;

  assign ok     = (cmd.fin_status == ST_OK);
  assign set_ok = cmd.finish && ok && (mode_r == MODE_SET);
  assign del_ok = cmd.finish && ok && (mode_r == MODE_DELETE);
  assign clr    = cmd.finish && (mode_r == MODE_CLEAR);
  assign tgt    = match_r ? pos_r : free_r;

  always_comb begin
    count_nxt = count_r;
    if (clr) begin
      count_nxt = '0;
    end else if (set_ok) begin
      if (!match_r) count_nxt = count_r + 1'b1;
    end else if (del_ok) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Marks are written one slot at a time: by the clearing pass, by a set or by
  // a delete. Every slot is wiped after reset before the first request is read.
  always_ff @(posedge clk) begin
    if (cmd.wipe) begin
      mark_mem[pos_r] <= MARK_EMPTY;
    end else if (set_ok) begin
      mark_mem[tgt] <= MARK_FULL;
    end else if (del_ok) begin
      mark_mem[pos_r] <= MARK_DELETED;
    end
    if (set_ok) begin
      hash_mem[tgt] <= hash_r;
      key_mem[tgt]  <= key_r;
      val_mem[tgt]  <= val_r;
    end
    if (cmd.rd_en) begin
      rd_mark_r <= mark_mem[pos_r];
      rd_hash_r <= hash_mem[pos_r];
      rd_key_r  <= key_mem[pos_r];
      rd_val_r  <= val_mem[pos_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      n_r        <= '0;
      has_free_r <= 1'b0;
      match_r    <= 1'b0;
    end else if (cmd.accept) begin
      mode_r     <= in_mode;
      key_r      <= in_key;
      hash_r     <= in_key_hash;
      val_r      <= in_value;
      start_r    <= in_start_slot;
      pos_r      <= (in_mode == MODE_ITERATE) ? in_start_slot[IDX_W-1:0] :
                    (in_mode == MODE_CLEAR)   ? '0 : in_key_hash[IDX_W-1:0];
      n_r        <= '0;
      has_free_r <= 1'b0;
      match_r    <= 1'b0;
    end else begin
      if (cmd.step) begin
        pos_r <= pos_r + 1'b1;
        n_r   <= n_r + 1'b1;
      end
      if (cmd.note_free && !has_free_r) begin
        free_r     <= pos_r;
        has_free_r <= 1'b1;
      end
      if (cmd.set_match) match_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status      <= cmd.fin_status;
      out_is_new      <= set_ok && !match_r;
      out_entry_count <= count_nxt;
      out_slot        <= (ok && mode_r != MODE_CLEAR) ?
                         ((mode_r == MODE_SET) ? tgt : pos_r) : '0;
      if (mode_r == MODE_ITERATE) begin
        if (ok) begin
          out_next_slot <= {1'b0, pos_r} + 1'b1;
        end else begin
          out_next_slot <= (start_r >= CNT_W'(CAPACITY)) ? start_r : CNT_W'(CAPACITY);
        end
      end else begin
        out_next_slot <= '0;
      end
      out_key   <= (ok && mode_r == MODE_ITERATE) ? rd_key_r : '0;
      out_hash  <= (ok && mode_r == MODE_ITERATE) ? rd_hash_r : '0;
      out_value <= (ok && (mode_r == MODE_ITERATE || mode_r == MODE_GET)) ? rd_val_r : '0;
    end
  end

  assign out_valid = out_valid_r;

  assign stat.mode         = mode_r;
  assign stat.count_zero   = (count_r == '0);
  assign stat.start_beyond = (in_start_slot >= CNT_W'(CAPACITY));
  assign stat.empty        = (rd_mark_r == MARK_EMPTY);
  assign stat.deleted      = (rd_mark_r == MARK_DELETED);
  assign stat.full         = (rd_mark_r == MARK_FULL);
  assign stat.key_match    = (rd_hash_r == hash_r) && (rd_key_r == key_r);
  assign stat.probe_last   = (n_r == IDX_W'(CAPACITY - 1));
  assign stat.pos_last     = (pos_r == IDX_W'(CAPACITY - 1));
  assign stat.has_free     = has_free_r;
  assign stat.out_free     = !out_valid_r || !out_stall;

  a_rise_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.finish))
    else $error("result word appeared without a finish command");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count exceeds capacity");
  a_hold_under_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> out_valid_r)
    else $error("stalled result word was dropped");
  a_one_mark_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.wipe && cmd.finish))
    else $error("wipe and finish in the same cycle");

endmodule

// ===== rtl/lpht_ctrl.sv =====
// Controller of the linear-probe hash table: sequences probes, scans, the
// clearing pass and result delivery. Depends on lpht_pkg.
module lpht_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [2:0]           in_mode,
  output logic                 in_stall,
  input  lpht_pkg::lpht_stat_t stat,
  output lpht_pkg::lpht_cmd_t  cmd
);
  import lpht_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PRD  = 3'd1;
  localparam logic [2:0] S_PCMP = 3'd2;
  localparam logic [2:0] S_IRD  = 3'd3;
  localparam logic [2:0] S_ICHK = 3'd4;
  localparam logic [2:0] S_WIPE = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;
  localparam logic [2:0] S_INIT = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic [1:0] res_r, res_nxt;
  logic       free_now, is_set;

  assign in_stall = (state_r != S_IDLE);
  assign free_now = stat.has_free || stat.empty || stat.deleted;
  assign is_set   = (stat.mode == MODE_SET);

  always_comb begin
    state_nxt      = state_r;
    res_nxt        = res_r;
    cmd            = '0;
    cmd.fin_status = res_r;
    unique case (state_r)
      S_INIT: begin
        cmd.wipe = 1'b1;
        cmd.step = 1'b1;
        if (stat.pos_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_DONE;
          case (in_mode) inside
            MODE_GET, MODE_DELETE: begin
              res_nxt = ST_NOT_FOUND;
              if (!stat.count_zero) state_nxt = S_PRD;
            end
            MODE_SET:   state_nxt = S_PRD;
            MODE_CLEAR: begin
              res_nxt   = ST_OK;
              state_nxt = S_WIPE;
            end
            MODE_ITERATE: begin
              res_nxt = ST_END;
              if (!stat.start_beyond) state_nxt = S_IRD;
            end
            default: res_nxt = ST_NOT_FOUND;
          endcase
        end
      end
      S_PRD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_PCMP;
      end
      S_PCMP: begin
        cmd.note_free = stat.empty || stat.deleted;
        if (stat.full && stat.key_match) begin
          cmd.set_match = 1'b1;
          res_nxt       = ST_OK;
          state_nxt     = S_DONE;
        end else if (stat.empty || stat.probe_last) begin
          if (is_set) begin
            res_nxt = free_now ? ST_OK : ST_FULL;
          end else begin
            res_nxt = ST_NOT_FOUND;
          end
          state_nxt = S_DONE;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = S_PRD;
        end
      end
      S_IRD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_ICHK;
      end
      S_ICHK: begin
        if (stat.full) begin
          res_nxt   = ST_OK;
          state_nxt = S_DONE;
        end else if (stat.pos_last) begin
          state_nxt = S_DONE;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = S_IRD;
        end
      end
      S_WIPE: begin
        cmd.wipe = 1'b1;
        cmd.step = 1'b1;
        if (stat.pos_last) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      res_r   <= ST_OK;
    end else begin
      state_r <= state_nxt;
      res_r   <= res_nxt;
    end
  end

  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> stat.out_free)
    else $error("finish issued while the result register is busy");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> in_stall)
    else $error("input not stalled after accepting a word");
  a_read_then_compare: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PCMP) |-> $past(cmd.rd_en))
    else $error("compare without a slot read in the cycle before");

endmodule

// ===== rtl/linear_probe_hash_table.sv =====
// Top level of the linear-probe hash table: controller plus datapath.
// Depends on lpht_pkg, lpht_ctrl and lpht_dp.
//
//   channel   direction   handshake             word
//   in_       in          in_valid / in_stall   mode, key, key_hash, value, start_slot
//   out_      out         out_valid / out_stall status, is_new, slot, next_slot,
//                                               key, hash, value, entry_count
//
// A get, set or delete visits each probed slot with a memory read, then a
// compare, through the single read port of the slot memories; at most all 256
// slots are probed. An iterate does the same for each slot scanned from start_slot.
// Clear walks all 256 slot marks, one per cycle.
// A get or delete on an empty table and an unused mode go straight to the result.
// After reset the same clearing pass marks every slot empty, so the input
// stays stalled until every slot is wiped; the count is zero at once.
// The input is stalled while a request is at work. The result register holds
// a word under out_stall, and the next request may be taken meanwhile; its
// result waits in the controller until the register is free.
module linear_probe_hash_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_mode,
  input  logic [31:0] in_key,
  input  logic [31:0] in_key_hash,
  input  logic [31:0] in_value,
  input  logic [8:0]  in_start_slot,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic        out_is_new,
  output logic [7:0]  out_slot,
  output logic [8:0]  out_next_slot,
  output logic [31:0] out_key,
  output logic [31:0] out_hash,
  output logic [31:0] out_value,
  output logic [8:0]  out_entry_count
);
  import lpht_pkg::*;

  // Commands and status are the only link between the two halves.
  lpht_cmd_t  cmd;
  lpht_stat_t stat;

  lpht_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  lpht_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_mode         (in_mode),
    .in_key          (in_key),
    .in_key_hash     (in_key_hash),
    .in_value        (in_value),
    .in_start_slot   (in_start_slot),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_is_new      (out_is_new),
    .out_slot        (out_slot),
    .out_next_slot   (out_next_slot),
    .out_key         (out_key),
    .out_hash        (out_hash),
    .out_value       (out_value),
    .out_entry_count (out_entry_count)
  );

endmodule

// ===== test/linear_probe_hash_table_tb.sv =====
// Self-checking testbench for linear_probe_hash_table: random and directed table requests
// are checked word by word against a predictor of the slot table kept in the bench.
// Depends on lpht_pkg and the linear_probe_hash_table RTL.
module linear_probe_hash_table_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lpht_pkg::*;

  // Mode codes that the block treats as unused.
  localparam logic [2:0] MODE_SPARE_A = 3'd5;
  localparam logic [2:0] MODE_SPARE_B = 3'd6;
  localparam logic [2:0] MODE_SPARE_C = 3'd7;

  // The slowest request probes every slot.
  localparam int DRAIN_CYCLES = 600;
  localparam int CYCLE_LIMIT  = 3000000;
  localparam int POOL_SIZE    = 48;
  localparam int FILL_KEYS    = 270;

  typedef enum logic [1:0] {SLOT_EMPTY, SLOT_DELETED, SLOT_FULL} slot_mark_t;

  // One request word plus the pacing hints for the driver.
  typedef struct {
    logic [2:0]  mode;
    logic [31:0] key;
    logic [31:0] hash;
    logic [31:0] value;
    logic [8:0]  start;
    bit          drain;  // hold this word back until every result has come
    bit          quiet;  // no idling on either side from here on
  } req_t;

  typedef struct {
    logic [1:0]  status;
    logic        is_new;
    logic [7:0]  slot;
    logic [8:0]  next_slot;
    logic [31:0] key;
    logic [31:0] hash;
    logic [31:0] value;
    logic [8:0]  count;
  } resp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_mode = '0;
  logic [31:0] in_key = '0;
  logic [31:0] in_key_hash = '0;
  logic [31:0] in_value = '0;
  logic [8:0]  in_start_slot = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic        out_is_new;
  logic [7:0]  out_slot;
  logic [8:0]  out_next_slot;
  logic [31:0] out_key;
  logic [31:0] out_hash;
  logic [31:0] out_value;
  logic [8:0]  out_entry_count;

  linear_probe_hash_table dut (.*);

  always #1 clk = ~clk;

  // Model of the slot table. Hash, key and value are only read from full slots.
  slot_mark_t  tbl_mark [CAPACITY];
  logic [31:0] tbl_hash [CAPACITY];
  logic [31:0] tbl_key  [CAPACITY];
  logic [31:0] tbl_value[CAPACITY];
  int          tbl_count;

  req_t  pending_q[$];
  resp_t result_q[$];
  req_t  cur_word;
  int    words_total;
  int    words_sent;
  int    errors;
  int    cycles;
  int    send_gap;
  int    recv_gap;
  int    hold_left;
  bit    hold_done;
  bit    quiet_now;
  bit    gen_quiet;
  bit    gen_drain;

  logic [31:0] pool_key [POOL_SIZE];
  logic [31:0] pool_hash[POOL_SIZE];
  logic [31:0] fill_key [FILL_KEYS];
  logic [31:0] fill_hash[FILL_KEYS];

  // Linear probe: returns the matching slot, else the first free slot passed, else -1.
  function automatic int probe_slot(input logic [31:0] k, input logic [31:0] h,
                                    output bit hit);
    int pos;
    int first_free;
    first_free = -1;
    hit = 1'b0;
    pos = int'(h % CAPACITY);
    for (int n = 0; n < CAPACITY; n++) begin
      if (tbl_mark[pos] == SLOT_EMPTY) begin
        if (first_free < 0) first_free = pos;
        return first_free;
      end
      if (tbl_mark[pos] == SLOT_DELETED) begin
        if (first_free < 0) first_free = pos;
      end else if (tbl_hash[pos] == h && tbl_key[pos] == k) begin
        hit = 1'b1;
        return pos;
      end
      pos = (pos + 1) % CAPACITY;
    end
    return first_free;
  endfunction

  // Applies one request to the table model and returns the word it must produce.
  function automatic resp_t apply_request(input req_t r);
    resp_t o;
    int    idx;
    bit    hit;
    o = '{default: '0};
    o.status = ST_NOT_FOUND;
    case (r.mode)
      MODE_GET: begin
        if (tbl_count != 0) begin
          idx = probe_slot(r.key, r.hash, hit);
          if (hit) begin
            o.status = ST_OK;
            o.slot = 8'(idx);
            o.value = tbl_value[idx];
          end
        end
      end
      MODE_SET: begin
        idx = probe_slot(r.key, r.hash, hit);
        if (idx < 0) begin
          o.status = ST_FULL;
        end else begin
          if (!hit) begin
            o.is_new = 1'b1;
            tbl_count++;
          end
          tbl_hash[idx] = r.hash;
          tbl_key[idx] = r.key;
          tbl_value[idx] = r.value;
          tbl_mark[idx] = SLOT_FULL;
          o.status = ST_OK;
          o.slot = 8'(idx);
        end
      end
      MODE_DELETE: begin
        if (tbl_count != 0) begin
          idx = probe_slot(r.key, r.hash, hit);
          if (hit) begin
            tbl_mark[idx] = SLOT_DELETED;
            tbl_count--;
            o.status = ST_OK;
            o.slot = 8'(idx);
          end
        end
      end
      MODE_CLEAR: begin
        foreach (tbl_mark[i]) tbl_mark[i] = SLOT_EMPTY;
        tbl_count = 0;
        o.status = ST_OK;
      end
      MODE_ITERATE: begin
        o.status = ST_END;
        o.next_slot = (r.start >= CAPACITY) ? r.start : 9'(CAPACITY);
        for (int p = r.start; p < CAPACITY; p++) begin
          if (tbl_mark[p] == SLOT_FULL) begin
            o.status = ST_OK;
            o.slot = 8'(p);
            o.next_slot = 9'(p + 1);
            o.key = tbl_key[p];
            o.hash = tbl_hash[p];
            o.value = tbl_value[p];
            break;
          end
        end
      end
      default: ;
    endcase
    o.count = 9'(tbl_count);
    return o;
  endfunction

  task automatic add_word(input logic [2:0] mode, input logic [31:0] k,
                          input logic [31:0] h, input logic [31:0] v,
                          input logic [8:0] start);
    req_t r;
    r.mode = mode;
    r.key = k;
    r.hash = h;
    r.value = v;
    r.start = start;
    r.drain = gen_drain;
    r.quiet = gen_quiet;
    gen_drain = 1'b0;
    pending_q.push_back(r);
  endtask

  // A request on the small key pool, so that keys collide, repeat and get deleted.
  // A few words are noise: any mode, a foreign key or a hash that does not fit the key.
  task automatic add_pool_word();
    int          pick;
    int          roll;
    logic [8:0]  start;
    pick = $urandom_range(0, POOL_SIZE - 1);
    roll = $urandom_range(0, 99);
    start = ($urandom_range(0, 7) == 0) ? 9'($urandom_range(256, 511))
                                        : 9'($urandom_range(0, 255));
    if (roll < 30)
      add_word(MODE_GET, pool_key[pick], pool_hash[pick], $urandom, start);
    else if (roll < 60)
      add_word(MODE_SET, pool_key[pick], pool_hash[pick], $urandom, start);
    else if (roll < 78)
      add_word(MODE_DELETE, pool_key[pick], pool_hash[pick], $urandom, start);
    else if (roll < 91)
      add_word(MODE_ITERATE, $urandom, $urandom, $urandom, start);
    else if (roll < 93)
      add_word(MODE_CLEAR, $urandom, $urandom, $urandom, start);
    else if (roll < 96)
      add_word(3'($urandom_range(0, 7)), $urandom, $urandom, $urandom,
               9'($urandom_range(0, 511)));
    else
      add_word(3'($urandom_range(0, 2)), pool_key[pick], $urandom, $urandom, start);
  endtask

  task automatic check_field(input string name, input logic [31:0] expd,
                             input logic [31:0] got);
    if (got !== expd) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, expd, got);
      errors++;
    end
  endtask

  // Driver: offers words from pending_q, holds a stalled word, and idles in bursts.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        result_q.push_back(apply_request(cur_word));
        words_sent++;
        if (!cur_word.quiet && $urandom_range(0, 4) == 0) send_gap = $urandom_range(1, 16);
      end
      if (in_valid && in_stall) begin
        // The stalled word stays on the port unchanged.
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_q.size() != 0 &&
                   !(pending_q[0].drain && result_q.size() != 0)) begin
        cur_word = pending_q.pop_front();
        quiet_now = cur_word.quiet;
        in_valid <= 1'b1;
        in_mode <= cur_word.mode;
        in_key <= cur_word.key;
        in_key_hash <= cur_word.hash;
        in_value <= cur_word.value;
        in_start_slot <= cur_word.start;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each result word against the oldest expectation and drives out_stall.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (result_q.size() == 0) begin
        $display("%0t: result word with nothing expected, expected none, actual status %0h",
                 $realtime, out_status);
        errors++;
      end else begin
        resp_t e;
        e = result_q.pop_front();
        check_field("status", 32'(e.status), 32'(out_status));
        check_field("is_new", 32'(e.is_new), 32'(out_is_new));
        check_field("slot", 32'(e.slot), 32'(out_slot));
        check_field("next_slot", 32'(e.next_slot), 32'(out_next_slot));
        check_field("key", e.key, out_key);
        check_field("hash", e.hash, out_hash);
        check_field("value", e.value, out_value);
        check_field("entry_count", 32'(e.count), 32'(out_entry_count));
      end
    end
    // One long hold-off while the sender keeps going, so the block backs up.
    if (!hold_done && words_sent >= 300) begin
      hold_done = 1'b1;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_stall <= 1'b1;
    end else if (!quiet_now && $urandom_range(0, 7) == 0) begin
      recv_gap = $urandom_range(0, 15);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    foreach (tbl_mark[i]) tbl_mark[i] = SLOT_EMPTY;
    tbl_count = 0;
    // Most pool hashes have a low byte of 0 to 15, so probes run through collision chains.
    foreach (pool_key[i]) begin
      pool_key[i] = $urandom;
      pool_hash[i] = {24'($urandom_range(0, 32'hFFFFFF)), 8'($urandom_range(0, 15))};
    end
    pool_key[0] = 32'h0;
    pool_hash[0] = 32'h0;
    pool_key[1] = 32'hFFFF_FFFF;
    pool_hash[1] = 32'hFFFF_FFFF;

    // Directed part: empty table, collisions, overwrite, tombstones, iterate edges,
    // unused modes and clear.
    add_word(MODE_GET, 32'h0, 32'h0, 32'h0, 9'd0);
    add_word(MODE_DELETE, 32'h0, 32'h0, 32'h0, 9'd0);
    add_word(MODE_ITERATE, 32'h0, 32'h0, 32'h0, 9'd0);
    add_word(MODE_ITERATE, 32'h0, 32'h0, 32'h0, 9'd256);
    add_word(MODE_ITERATE, 32'h0, 32'h0, 32'h0, 9'd511);
    add_word(MODE_SET, 32'h0, 32'h0, 32'h0, 9'd0);
    add_word(MODE_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 9'd0);
    add_word(MODE_SET, 32'h5A5A_5A5A, 32'h0000_0100, 32'h1111_1111, 9'd0);
    add_word(MODE_GET, 32'h5A5A_5A5A, 32'h0000_0100, 32'h0, 9'd0);
    add_word(MODE_SET, 32'h0, 32'h0, 32'h1234_5678, 9'd0);
    add_word(MODE_GET, 32'h0, 32'h0, 32'h0, 9'd0);
    add_word(MODE_GET, 32'h0, 32'h0000_0100, 32'h0, 9'd0);
    add_word(MODE_DELETE, 32'h0, 32'h0, 32'h0, 9'd0);
    add_word(MODE_DELETE, 32'h0, 32'h0, 32'h0, 9'd0);
    add_word(MODE_GET, 32'h5A5A_5A5A, 32'h0000_0100, 32'h0, 9'd0);
    add_word(MODE_SET, 32'hA5A5_A5A5, 32'h0000_0200, 32'h2222_2222, 9'd0);
    add_word(MODE_ITERATE, 32'h0, 32'h0, 32'h0, 9'd1);
    add_word(MODE_ITERATE, 32'h0, 32'h0, 32'h0, 9'd255);
    add_word(MODE_SPARE_A, 32'h0, 32'h0, 32'h0, 9'd0);
    add_word(MODE_SPARE_B, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 9'd511);
    add_word(MODE_SPARE_C, 32'h0, 32'h0, 32'h0, 9'd0);
    add_word(MODE_CLEAR, 32'h0, 32'h0, 32'h0, 9'd0);
    add_word(MODE_GET, 32'h5A5A_5A5A, 32'h0000_0100, 32'h0, 9'd0);

    // Mixed traffic on the key pool; the first word waits for the pipe to empty.
    gen_drain = 1'b1;
    repeat (700) add_pool_word();

    // Fill the table until sets report it full, then punch holes and refill.
    gen_drain = 1'b1;
    add_word(MODE_CLEAR, $urandom, $urandom, $urandom, 9'd0);
    foreach (fill_key[i]) begin
      fill_key[i] = {1'b1, 23'($urandom), 8'(i)} ^ (i << 8);
      fill_hash[i] = $urandom;
      add_word(MODE_SET, fill_key[i], fill_hash[i], $urandom, 9'd0);
    end
    repeat (20) begin
      int j;
      j = $urandom_range(0, FILL_KEYS - 1);
      add_word(MODE_GET, fill_key[j], fill_hash[j], $urandom, 9'd0);
    end
    add_word(MODE_GET, 32'h1234_5678, $urandom, $urandom, 9'd0);
    repeat (40) begin
      int j;
      j = $urandom_range(0, FILL_KEYS - 1);
      add_word(MODE_DELETE, fill_key[j], fill_hash[j], $urandom, 9'd0);
    end
    repeat (30) begin
      int j;
      j = $urandom_range(0, FILL_KEYS - 1);
      add_word(MODE_SET, fill_key[j], fill_hash[j], $urandom, 9'd0);
      add_word(MODE_ITERATE, $urandom, $urandom, $urandom, 9'($urandom_range(0, 256)));
    end
    add_word(MODE_CLEAR, $urandom, $urandom, $urandom, 9'd0);

    // Closing stretch with no idling on either side.
    gen_quiet = 1'b1;
    repeat (250) add_pool_word();
    words_total = pending_q.size();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    while (words_sent < words_total || result_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/lpht_pkg.sv
rtl/lpht_dp.sv
rtl/lpht_ctrl.sv
rtl/linear_probe_hash_table.sv
test/linear_probe_hash_table_tb.sv
